/* src/mhpq_pkg.sv */
// Package for the min-heap priority queue: state, opcode and status codes,
// plus the default capacity. No dependencies.
package mhpq_pkg;

   localparam int HEAP_CAPACITY_DEFAULT = 128;
   localparam int KEY_W = 32;
   localparam int OCC_W = 8;

   typedef logic signed [KEY_W-1:0] key_type;

   typedef enum logic [0:0] {
      OP_INSERT  = 1'b0,
      OP_EXTRACT = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_INSERTED = 2'd0,
      STATUS_FULL     = 2'd1,
      STATUS_MIN      = 2'd2,
      STATUS_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXT_RD,
      ST_UP_RD,
      ST_UP_CMP,
      ST_DN_RD,
      ST_DN_CMP
   } state_type;

endpackage

/* src/min_heap_priority_queue_top.sv */
// Binary min-heap priority queue, top level. Heap array in one synchronous
// memory (one write, two read ports); depends on mhpq_pkg.
//
// Sequencing: a full insert or empty extract answers in the cycle after accept.
//   Insert: each parent compared takes an UP_RD read and an UP_CMP compare/write.
//   Extract: EXT_RD reads root and last entry, then DN_RD and DN_CMP per level down.
// Throughput: one operation at a time; the sift loop (read, then compare and
//   write back) sets the rate. busy drops in the cycle the result is shown.
// Reset: synchronous, clears the element count and control; the heap memory
//   holds no reset value, and entries at or above the count are never used.
module min_heap_priority_queue_top
   import mhpq_pkg::*;
#(
   parameter int CAPACITY = HEAP_CAPACITY_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_op,
   input  logic signed [KEY_W-1:0] req_key_in,
   output logic                    rsp_strobe,
   output logic signed [KEY_W-1:0] rsp_key_out,
   output logic [1:0]              rsp_status,
   output logic [OCC_W-1:0]        rsp_occupancy
);

   localparam int AW = $clog2(CAPACITY);       // heap address
   localparam int CW = $clog2(CAPACITY + 1);   // count, holds CAPACITY itself
   localparam int LW = CW + 1;                 // child index, up to 2*CAPACITY

   // heap storage
   key_type mem [CAPACITY];
   logic    mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr_a, mem_raddr_b;
   key_type mem_wdata, rd_a_ff, rd_b_ff;

   // control and working registers
   state_type     state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] pos_ff, pos_in;
   key_type       key_ff, key_in;      // key being sifted (hole method)
   key_type       root_ff, root_in;    // extracted minimum

   // result beat
   logic          strobe_ff, strobe_in;
   key_type       out_key_ff, out_key_in;
   status_type    out_status_ff, out_status_in;
   logic [CW-1:0] out_occ_ff, out_occ_in;

   logic          accept;
   logic [AW-1:0] parent;
   logic [LW-1:0] left_idx, right_idx, count_w;
   logic          left_ok, right_ok, take_left, take_right;

   assign accept    = start && (state_ff == ST_IDLE);
   assign parent    = AW'((pos_ff - AW'(1)) >> 1);
   assign left_idx  = LW'({pos_ff, 1'b1});
   assign right_idx = left_idx + LW'(1);
   assign count_w   = LW'(count_ff);
   assign left_ok   = left_idx < count_w;
   assign right_ok  = right_idx < count_w;

   // smaller child wins, left on a tie; must be strictly below the moving key
   always_comb begin
      take_left  = 1'b0;
      take_right = 1'b0;
      if (left_ok && right_ok && (rd_b_ff < rd_a_ff)) begin
         take_right = rd_b_ff < key_ff;
      end else if (left_ok) begin
         take_left = rd_a_ff < key_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rd_a_ff <= mem[mem_raddr_a];
      rd_b_ff <= mem[mem_raddr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      key_ff        <= key_in;
      root_ff       <= root_in;
      out_key_ff    <= out_key_in;
      out_status_ff <= out_status_in;
      out_occ_ff    <= out_occ_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      key_in        = key_ff;
      root_in       = root_ff;
      strobe_in     = 1'b0;
      out_key_in    = out_key_ff;
      out_status_in = out_status_ff;
      out_occ_in    = out_occ_ff;
      mem_we        = 1'b0;
      mem_waddr     = pos_ff;
      mem_wdata     = key_ff;
      mem_raddr_a   = '0;
      mem_raddr_b   = AW'(count_ff - CW'(1));

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (op_type'(req_op) == OP_INSERT) begin
                  if (count_ff == CW'(CAPACITY)) begin
                     strobe_in     = 1'b1;
                     out_key_in    = '0;
                     out_status_in = STATUS_FULL;
                     out_occ_in    = count_ff;
                  end else begin
                     key_in   = req_key_in;
                     pos_in   = count_ff[AW-1:0];
                     count_in = count_ff + CW'(1);
                     state_in = ST_UP_RD;
                  end
               end else begin
                  if (count_ff == '0) begin
                     strobe_in     = 1'b1;
                     out_key_in    = '0;
                     out_status_in = STATUS_EMPTY;
                     out_occ_in    = count_ff;
                  end else begin
                     // root on port a, last entry on port b
                     count_in = count_ff - CW'(1);
                     state_in = ST_EXT_RD;
                  end
               end
            end
         end

         ST_EXT_RD: begin
            root_in = rd_a_ff;
            if (count_ff == '0) begin
               strobe_in     = 1'b1;
               out_key_in    = rd_a_ff;
               out_status_in = STATUS_MIN;
               out_occ_in    = count_ff;
               state_in      = ST_IDLE;
            end else begin
               key_in   = rd_b_ff;
               pos_in   = '0;
               state_in = ST_DN_RD;
            end
         end

         ST_UP_RD: begin
            mem_raddr_a = parent;
            if (pos_ff == '0) begin
               mem_we        = 1'b1;
               strobe_in     = 1'b1;
               out_key_in    = '0;
               out_status_in = STATUS_INSERTED;
               out_occ_in    = count_ff;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_UP_CMP;
            end
         end

         ST_UP_CMP: begin
            mem_we = 1'b1;
            if (key_ff < rd_a_ff) begin
               // parent moves down into the hole
               mem_wdata = rd_a_ff;
               pos_in    = parent;
               state_in  = ST_UP_RD;
            end else begin
               strobe_in     = 1'b1;
               out_key_in    = '0;
               out_status_in = STATUS_INSERTED;
               out_occ_in    = count_ff;
               state_in      = ST_IDLE;
            end
         end

         ST_DN_RD: begin
            mem_raddr_a = left_idx[AW-1:0];
            mem_raddr_b = right_idx[AW-1:0];
            state_in    = ST_DN_CMP;
         end

         ST_DN_CMP: begin
            mem_we = 1'b1;
            priority if (take_right) begin
               mem_wdata = rd_b_ff;
               pos_in    = right_idx[AW-1:0];
               state_in  = ST_DN_RD;
            end else if (take_left) begin
               mem_wdata = rd_a_ff;
               pos_in    = left_idx[AW-1:0];
               state_in  = ST_DN_RD;
            end else begin
               strobe_in     = 1'b1;
               out_key_in    = root_ff;
               out_status_in = STATUS_MIN;
               out_occ_in    = count_ff;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_strobe    = strobe_ff;
   assign rsp_key_out   = out_key_ff;
   assign rsp_status    = out_status_ff;
   assign rsp_occupancy = OCC_W'(out_occ_ff);

   // count never passes capacity
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(CAPACITY))
      else $error("element count above capacity");

   // a result beat leaves the block ready for the next request
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while busy");

   // every accepted request either starts work or answers at once
   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted request dropped");

   // key_out carries a value only on a successful extract
   a_key_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && out_status_ff != STATUS_MIN) |-> (rsp_key_out == '0))
      else $error("nonzero key on non-extract result");

   // writes stay inside the live heap
   a_write_live: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (CW'(mem_waddr) < count_ff))
      else $error("heap write beyond element count");

endmodule

/* sim/min_heap_priority_queue_top_tb.sv */
// Self-checking bench for min_heap_priority_queue_top: random and directed
// insert/extract-min beats checked against an in-bench heap predictor.
// Depends on mhpq_pkg and the RTL top level only.
module min_heap_priority_queue_top_tb
   import mhpq_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CAPACITY    = HEAP_CAPACITY_DEFAULT;
   localparam int CYCLE_LIMIT = 400_000;  // well above the longest run of beats, gaps and sifts

   // One queued request beat: gap = idle cycles before it is offered,
   // hold = wait for every outstanding result before offering it.
   typedef struct {
      op_type  op;
      key_type key;
      int      gap;
      bit      hold;
   } heap_req_type;

   // One predicted result beat.
   typedef struct {
      key_type    key;
      status_type status;
      logic [OCC_W-1:0] occ;
   } heap_result_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   logic                    req_op = 1'b0;
   logic signed [KEY_W-1:0] req_key_in = '0;
   logic                    rsp_strobe;
   logic signed [KEY_W-1:0] rsp_key_out;
   logic [1:0]              rsp_status;
   logic [OCC_W-1:0]        rsp_occupancy;

   heap_req_type    req_queue[$];    // beats still to be offered
   heap_result_type heap_expect[$];  // predicted results, oldest first

   // Predictor state: its own copy of the heap and the key count.
   key_type heap_keys [CAPACITY];
   int      heap_count = 0;

   int errors = 0;
   int cycles = 0;
   int beats_sent = 0;
   int status_seen [4] = '{default: 0};

   min_heap_priority_queue_top #(
      .CAPACITY(CAPACITY)
   ) dut (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_op       (req_op),
      .req_key_in   (req_key_in),
      .rsp_strobe   (rsp_strobe),
      .rsp_key_out  (rsp_key_out),
      .rsp_status   (rsp_status),
      .rsp_occupancy(rsp_occupancy)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Apply one accepted request to the predictor heap and queue its result.
   // Insert sifts up while the parent is strictly greater; extract moves the
   // last key to the root and sifts down toward the smaller child, left
   // child winning a tie, only while that child is strictly smaller.
   function automatic void apply_heap_op(op_type op, key_type key);
      heap_result_type r;
      int pos;
      int parent;
      int best;
      int child;
      key_type t;
      r.key = '0;
      if (op == OP_INSERT) begin
         if (heap_count >= CAPACITY) begin
            r.status = STATUS_FULL;  // dropped, heap untouched
         end else begin
            r.status = STATUS_INSERTED;
            heap_keys[heap_count] = key;
            pos = heap_count;
            heap_count++;
            while (pos != 0) begin
               parent = (pos - 1) / 2;
               if (!(heap_keys[pos] < heap_keys[parent])) break;
               t = heap_keys[pos];
               heap_keys[pos] = heap_keys[parent];
               heap_keys[parent] = t;
               pos = parent;
            end
         end
      end else begin
         if (heap_count == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.status = STATUS_MIN;
            r.key = heap_keys[0];
            heap_count--;
            if (heap_count > 0) begin
               heap_keys[0] = heap_keys[heap_count];
               pos = 0;
               while (1) begin
                  best = pos;
                  child = 2 * pos + 1;
                  if (child < heap_count && heap_keys[child] < heap_keys[best])
                     best = child;
                  if (child + 1 < heap_count && heap_keys[child + 1] < heap_keys[best])
                     best = child + 1;
                  if (best == pos) break;
                  t = heap_keys[pos];
                  heap_keys[pos] = heap_keys[best];
                  heap_keys[best] = t;
                  pos = best;
               end
            end
         end
      end
      r.occ = OCC_W'(heap_count);
      heap_expect.push_back(r);
   endfunction

   // Keys: wide random, a narrow band around zero for lots of ties, and
   // the signed extremes or -1, 0 and 1.
   function automatic key_type pick_key();
      int unsigned sel;
      sel = $urandom_range(0, 9);
      if (sel < 4) return key_type'($urandom);
      if (sel < 8) return key_type'($urandom_range(0, 15)) - 8;
      case ($urandom_range(0, 4))
         0:       return key_type'(32'h8000_0000);
         1:       return key_type'(32'h7fff_ffff);
         2:       return key_type'(-1);
         3:       return key_type'(0);
         default: return key_type'(1);
      endcase
   endfunction

   // Sender gaps: mostly back to back, some short, a few long.
   function automatic int pick_gap();
      int unsigned sel;
      sel = $urandom_range(0, 99);
      if (sel < 70) return 0;
      if (sel < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 60);
   endfunction

   function automatic void add_beat(op_type op, key_type key, bit hold);
      heap_req_type b;
      b.op   = op;
      b.key  = key;
      b.gap  = pick_gap();
      b.hold = hold;
      req_queue.push_back(b);
   endfunction

   // Random segment: insert_pct sets the drift, so long insert-heavy runs
   // reach a full heap and extract-heavy runs empty it again.
   function automatic void add_segment(int len, int insert_pct);
      for (int i = 0; i < len; i++) begin
         add_beat(($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_EXTRACT,
                  pick_key(), $urandom_range(0, 59) == 0);
      end
   endfunction

   // Stimulus. Extract beats carry keys too; the block ignores them.
   initial begin : stim_proc
      int total;
      int pct_sel;
      // Directed: empty extract, extremes, duplicates, full drain.
      add_beat(OP_EXTRACT, pick_key(), 1'b0);
      add_beat(OP_INSERT, 0, 1'b0);
      add_beat(OP_INSERT, key_type'(32'h7fff_ffff), 1'b0);
      add_beat(OP_INSERT, key_type'(32'h8000_0000), 1'b0);
      add_beat(OP_INSERT, -1, 1'b0);
      add_beat(OP_INSERT, 1, 1'b0);
      add_beat(OP_INSERT, key_type'(32'h7fff_ffff), 1'b0);
      add_beat(OP_INSERT, key_type'(32'h8000_0000), 1'b0);
      add_beat(OP_INSERT, 7, 1'b0);
      for (int i = 0; i < 8; i++) add_beat(OP_EXTRACT, key_type'($urandom), 1'b0);
      add_beat(OP_EXTRACT, key_type'(32'hffff_ffff), 1'b0);
      // Equal keys: sift-down must settle ties toward the left child.
      add_beat(OP_INSERT, 5, 1'b0);
      add_beat(OP_INSERT, 5, 1'b0);
      add_beat(OP_INSERT, 3, 1'b0);
      add_beat(OP_INSERT, 5, 1'b0);
      for (int i = 0; i < 4; i++) add_beat(OP_EXTRACT, 0, 1'b0);
      // Pause the sender once until the heap has answered everything.
      add_beat(OP_INSERT, pick_key(), 1'b1);
      // Fill past capacity, then drain past empty.
      add_segment(200, 95);
      add_segment(200, 95 - 90);
      total = req_queue.size();
      while (total < 1000) begin
         pct_sel = $urandom_range(0, 2);
         add_segment($urandom_range(30, 150), (pct_sel == 0) ? 85 : (pct_sel == 1) ? 50 : 15);
         total = req_queue.size();
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // Driver: start stays up until a beat is taken (start && !busy). On the
   // taking edge the predictor sees the beat, and the next one goes out
   // right away when its gap is zero and it is not held, so start gets a single NBA per edge.
   always @(posedge clock) begin : drive_proc
      logic take;
      logic next_start;
      take = start && !busy;
      next_start = start && !take;
      if (reset) begin
         next_start = 1'b0;
      end else begin
         if (take) apply_heap_op(op_type'(req_op), req_key_in);
         if (!next_start && req_queue.size() != 0) begin
            if (req_queue[0].gap != 0) begin
               req_queue[0].gap = req_queue[0].gap - 1;
            end else if (!req_queue[0].hold || heap_expect.size() == 0) begin
               req_op     <= req_queue[0].op;
               req_key_in <= req_queue[0].key;
               next_start = 1'b1;
               void'(req_queue.pop_front());
               beats_sent++;
            end
         end
      end
      start <= next_start;
   end

   // Monitor: a result beat lives one cycle under rsp_strobe; compare it
   // with the oldest prediction.
   always @(posedge clock) begin : check_proc
      heap_result_type want;
      if (!reset && rsp_strobe) begin
         status_seen[rsp_status]++;
         if (heap_expect.size() == 0) begin
            $error("result beat with nothing expected: key_out %0d status %0d occupancy %0d",
                   rsp_key_out, rsp_status, rsp_occupancy);
            errors++;
         end else begin
            want = heap_expect.pop_front();
            if (rsp_key_out !== want.key) begin
               $error("key_out expected %0d actual %0d", want.key, rsp_key_out);
               errors++;
            end
            if (rsp_status !== want.status) begin
               $error("status expected %0d actual %0d", want.status, rsp_status);
               errors++;
            end
            if (rsp_occupancy !== want.occ) begin
               $error("occupancy expected %0d actual %0d", want.occ, rsp_occupancy);
               errors++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // End of run: all beats taken, all results in, then a settle window
   // longer than the deepest sift to catch stray result beats.
   initial begin
      @(negedge reset);
      while (req_queue.size() != 0 || start || heap_expect.size() != 0)
         @(posedge clock);
      repeat (40) @(posedge clock);
      $display("Run covered %0d request beats in %0d cycles", beats_sent, cycles);
      $display("Results: %0d inserted, %0d dropped full, %0d minima, %0d empty extracts",
               status_seen[STATUS_INSERTED], status_seen[STATUS_FULL],
               status_seen[STATUS_MIN], status_seen[STATUS_EMPTY]);
      if (errors == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
